// ----- hw/rtl/lps_pkg.sv -----
`default_nettype none
package lps_pkg;

	localparam int CNT_W = 16;
	localparam int REG_W = 16;
	localparam int CMP_W = (CNT_W > REG_W) ? CNT_W : REG_W;
	localparam int IDX_W = 3;
	localparam int IN_W  = 8;
	localparam int OUT_W = 8;

	localparam logic [REG_W-1:0] BUZZ_TICKS_RST = REG_W'(1200);

	typedef logic [2:0] phase_t;

	localparam phase_t PH_WAIT    = 3'd0;
	localparam phase_t PH_PULSE   = 3'd1;
	localparam phase_t PH_OFF     = 3'd2;
	localparam phase_t PH_BUZZ    = 3'd3;
	localparam phase_t PH_RELEASE = 3'd4;
	localparam phase_t PH_FAULT   = 3'd5;

	localparam logic [IDX_W-1:0] REG_OFF_TIME    = 3'd0;
	localparam logic [IDX_W-1:0] REG_PULSES_SQ   = 3'd1;
	localparam logic [IDX_W-1:0] REG_AUTO_REPEAT = 3'd2;
	localparam logic [IDX_W-1:0] REG_SLIDE_MODE  = 3'd3;
	localparam logic [IDX_W-1:0] REG_BUZZ_TICKS  = 3'd4;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/laser_pulse_sequencer_top.sv -----
// result: registered, valid in the cycle after its input transfer
// throughput: one tick per cycle, set by the single state update register
// stage; input stalls while a result is held and not yet taken
// reset: arst_n clears sequencer state, counters and output valid at once;
// registers come up at their documented reset values
`default_nettype none
module laser_pulse_sequencer_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	// system_ready, trigger, pulse_done, wrong_current, 4'b0
	input  wire logic [lps_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	// phase[2:0], laser_enable, buzzer_on, pulse_start, pulse_in_progress,
	// fault_request
	output logic [lps_pkg::OUT_W-1:0]      m_axis_tdata,
	input  wire logic                      cfg_we,
	input  wire logic [lps_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [lps_pkg::REG_W-1:0] cfg_data
);
	import lps_pkg::*;

	logic [REG_W-1:0] off_time_q, pulses_sq_q, buzz_ticks_q;
	logic             auto_repeat_q, slide_mode_q;

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] off_cnt_q, off_cnt_d;
	logic [CNT_W-1:0] slide_cnt_q, slide_cnt_d;
	logic [CNT_W-1:0] buzz_cnt_q, buzz_cnt_d;
	logic             buzzer_q, buzzer_d;
	logic             laser_q, laser_d;
	logic             busy_q, busy_d;
	logic             start_d, fault_d;

	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic in_xfer;
	logic rdy, trig, done, wrong;

	assign rdy   = s_axis_tdata[0];
	assign trig  = s_axis_tdata[1];
	assign done  = s_axis_tdata[2];
	assign wrong = s_axis_tdata[3];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_time_q    <= '0;
			pulses_sq_q   <= '0;
			auto_repeat_q <= 1'b0;
			slide_mode_q  <= 1'b0;
			buzz_ticks_q  <= BUZZ_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFF_TIME:    off_time_q    <= cfg_data;
				REG_PULSES_SQ:   pulses_sq_q   <= cfg_data;
				REG_AUTO_REPEAT: auto_repeat_q <= cfg_data[0];
				REG_SLIDE_MODE:  slide_mode_q  <= cfg_data[0];
				REG_BUZZ_TICKS:  buzz_ticks_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state for one tick
	always_comb begin
		phase_d     = phase_q;
		off_cnt_d   = off_cnt_q;
		slide_cnt_d = slide_cnt_q;
		buzz_cnt_d  = buzz_cnt_q;
		buzzer_d    = buzzer_q;
		laser_d     = laser_q;
		busy_d      = busy_q;
		start_d     = 1'b0;
		fault_d     = 1'b0;
		if (!rdy) begin
			buzzer_d = 1'b0;
			busy_d   = 1'b0;
			phase_d  = PH_WAIT;
		end else begin
			unique case (phase_q)
				PH_PULSE: begin
					if (done) begin
						buzzer_d  = 1'b0;
						off_cnt_d = '0;
						phase_d   = PH_OFF;
					end else if (wrong) begin
						buzzer_d = 1'b0;
						fault_d  = 1'b1;
						phase_d  = PH_FAULT;
					end
				end
				PH_OFF: begin
					buzzer_d = 1'b0;
					if (CMP_W'(off_cnt_q) >= CMP_W'(off_time_q)) begin
						if (auto_repeat_q) begin
							if (slide_mode_q &&
								CMP_W'(slide_cnt_q) >= CMP_W'(pulses_sq_q)) begin
								slide_cnt_d = '0;
								buzz_cnt_d  = '0;
								buzzer_d    = 1'b1;
								phase_d     = PH_BUZZ;
							end else begin
								phase_d = PH_WAIT;
							end
						end else begin
							phase_d = PH_RELEASE;
						end
					end else begin
						off_cnt_d = sat_inc(off_cnt_q);
					end
				end
				PH_BUZZ: begin
					if (CMP_W'(buzz_cnt_q) > CMP_W'(buzz_ticks_q)) begin
						buzzer_d = 1'b0;
						phase_d  = PH_RELEASE;
					end else begin
						buzz_cnt_d = sat_inc(buzz_cnt_q);
					end
				end
				PH_RELEASE: begin
					if (!trig)
						phase_d = PH_WAIT;
				end
				PH_FAULT: ;
				default: begin
					if (trig) begin
						busy_d      = 1'b1;
						buzzer_d    = 1'b1;
						laser_d     = 1'b1;
						start_d     = 1'b1;
						slide_cnt_d = sat_inc(slide_cnt_q);
						phase_d     = PH_PULSE;
					end else begin
						laser_d  = 1'b0;
						buzzer_d = 1'b0;
						phase_d  = PH_WAIT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			off_cnt_q   <= '0;
			slide_cnt_q <= '0;
			buzz_cnt_q  <= '0;
			buzzer_q    <= 1'b0;
			laser_q     <= 1'b0;
			busy_q      <= 1'b0;
		end else if (in_xfer) begin
			phase_q     <= phase_d;
			off_cnt_q   <= off_cnt_d;
			slide_cnt_q <= slide_cnt_d;
			buzz_cnt_q  <= buzz_cnt_d;
			buzzer_q    <= buzzer_d;
			laser_q     <= laser_d;
			busy_q      <= busy_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_data_q <= {fault_d, busy_d, start_d, buzzer_d, laser_d, phase_d};
		end
	end

endmodule
`default_nettype wire

// ----- sim/tb_laser_pulse_sequencer_top.sv -----
module tb_laser_pulse_sequencer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lps_pkg::*;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [3:0] pad;
		logic       wrong;
		logic       done;
		logic       trig;
		logic       ready;
	} tick_t;

	typedef struct packed {
		logic   fault;
		logic   busy;
		logic   start;
		logic   buzzer;
		logic   laser;
		phase_t phase;
	} status_t;

	typedef struct packed {
		phase_t phase;
		cnt_t   off_cnt;
		cnt_t   slide_cnt;
		cnt_t   buzz_cnt;
		logic   buzzer;
		logic   laser;
		logic   busy;
	} seq_state_t;

	// wrong, done, trigger, ready
	localparam logic [3:0] DIRECTED [24] = '{
		4'b0000, 4'b0001, 4'b0011, 4'b0011, 4'b1111, 4'b0011, 4'b0011, 4'b0001,
		4'b0011, 4'b1001, 4'b1111, 4'b1110, 4'b0001, 4'b0011, 4'b0010, 4'b0011,
		4'b0101, 4'b0000, 4'b0011, 4'b1101, 4'b1001, 4'b0101, 4'b1111, 4'b0001
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	// system_ready, trigger, pulse_done, wrong_current, 4'b0
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	// phase[2:0], laser_enable, buzzer_on, pulse_start, pulse_in_progress,
	// fault_request
	logic [OUT_W-1:0] m_axis_tdata;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;

	tick_t   pending_ticks[$];
	status_t expected_status[$];

	seq_state_t seq = '{phase: PH_WAIT, default: '0};
	logic [REG_W-1:0] off_time_cfg = '0;
	logic [REG_W-1:0] pulses_cfg = '0;
	logic             auto_cfg = 1'b0;
	logic             slide_cfg = 1'b0;
	logic [REG_W-1:0] buzz_ticks_cfg = BUZZ_TICKS_RST;

	int   error_count = 0;
	int   results_checked = 0;
	int   ticks_sent = 0;
	int   settings_used = 0;
	logic [7:0] phases_seen = '0;

	laser_pulse_sequencer_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic cnt_t count_up(cnt_t v);
		return (v == '1) ? v : v + cnt_t'(1);
	endfunction

	function automatic status_t advance_sequencer(tick_t t);
		status_t s;
		s = '0;
		if (!t.ready) begin
			seq.buzzer = 1'b0;
			seq.busy = 1'b0;
			seq.phase = PH_WAIT;
		end else begin
			case (seq.phase)
				PH_PULSE: begin
					if (t.done) begin
						seq.buzzer = 1'b0;
						seq.off_cnt = '0;
						seq.phase = PH_OFF;
					end else if (t.wrong) begin
						seq.buzzer = 1'b0;
						s.fault = 1'b1;
						seq.phase = PH_FAULT;
					end
				end
				PH_OFF: begin
					seq.buzzer = 1'b0;
					if (seq.off_cnt >= off_time_cfg) begin
						if (!auto_cfg) begin
							seq.phase = PH_RELEASE;
						end else if (slide_cfg && seq.slide_cnt >= pulses_cfg) begin
							seq.slide_cnt = '0;
							seq.buzz_cnt = '0;
							seq.buzzer = 1'b1;
							seq.phase = PH_BUZZ;
						end else begin
							seq.phase = PH_WAIT;
						end
					end else begin
						seq.off_cnt = count_up(seq.off_cnt);
					end
				end
				PH_BUZZ: begin
					if (seq.buzz_cnt > buzz_ticks_cfg) begin
						seq.buzzer = 1'b0;
						seq.phase = PH_RELEASE;
					end else begin
						seq.buzz_cnt = count_up(seq.buzz_cnt);
					end
				end
				PH_RELEASE: begin
					if (!t.trig)
						seq.phase = PH_WAIT;
				end
				PH_FAULT: begin
				end
				default: begin
					if (t.trig) begin
						seq.busy = 1'b1;
						seq.buzzer = 1'b1;
						seq.laser = 1'b1;
						s.start = 1'b1;
						seq.slide_cnt = count_up(seq.slide_cnt);
						seq.phase = PH_PULSE;
					end else begin
						seq.laser = 1'b0;
						seq.buzzer = 1'b0;
						seq.phase = PH_WAIT;
					end
				end
			endcase
		end
		s.phase = seq.phase;
		s.laser = seq.laser;
		s.buzzer = seq.buzzer;
		s.busy = seq.busy;
		return s;
	endfunction

	task automatic check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			error_count++;
		end
	endtask

	// sender: bursts and gaps, with drain pauses
	int burst_left = 0;
	int gap_left = 0;
	bit drain_req = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (drain_req) begin
				s_axis_tvalid <= 1'b0;
				if (!s_axis_tvalid && expected_status.size() == 0)
					drain_req = 1'b0;
			end else if (gap_left != 0 || pending_ticks.size() == 0) begin
				s_axis_tvalid <= 1'b0;
				if (gap_left != 0)
					gap_left--;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_ticks.pop_front();
				ticks_sent++;
				if (ticks_sent == 300 || $urandom_range(0, 99) == 0)
					drain_req = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 20);
					gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// receiver: random stall pattern, redrawn when its hold counter runs out
	int stall_mode = 0;
	int stall_left = 0;
	int stall_phase = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 80);
			end else begin
				stall_left--;
			end
			stall_phase = (stall_phase + 1) % 3;
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 99) >= 25);
				2: m_axis_tready <= ($urandom_range(0, 99) >= 75);
				default: m_axis_tready <= (stall_phase == 0);
			endcase
		end
	end

	// monitor: register writes, input transfers, output transfers
	always @(posedge clk) begin
		tick_t   t;
		status_t got;
		status_t exp_s;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OFF_TIME:    off_time_cfg = cfg_data;
					REG_PULSES_SQ:   pulses_cfg = cfg_data;
					REG_AUTO_REPEAT: auto_cfg = cfg_data[0];
					REG_SLIDE_MODE:  slide_cfg = cfg_data[0];
					REG_BUZZ_TICKS:  buzz_ticks_cfg = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				t = tick_t'(s_axis_tdata);
				exp_s = advance_sequencer(t);
				phases_seen[exp_s.phase] = 1'b1;
				expected_status.push_back(exp_s);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = status_t'(m_axis_tdata);
				if (expected_status.size() == 0) begin
					$error("unexpected result transfer: %h", m_axis_tdata);
					error_count++;
				end else begin
					exp_s = expected_status.pop_front();
					check_field("phase", int'(exp_s.phase), int'(got.phase));
					check_field("laser_enable", int'(exp_s.laser), int'(got.laser));
					check_field("buzzer_on", int'(exp_s.buzzer), int'(got.buzzer));
					check_field("pulse_start", int'(exp_s.start), int'(got.start));
					check_field("pulse_in_progress", int'(exp_s.busy), int'(got.busy));
					check_field("fault_request", int'(exp_s.fault), int'(got.fault));
					results_checked++;
				end
			end
		end
	end

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_ticks.size() != 0 || s_axis_tvalid || expected_status.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic program_sequencer(input logic [REG_W-1:0] off_t, input logic [REG_W-1:0] pps,
			input logic auto_rep, input logic slide, input logic [REG_W-1:0] buzz);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_OFF_TIME;
		cfg_data <= off_t;
		@(posedge clk);
		cfg_index <= REG_PULSES_SQ;
		cfg_data <= pps;
		@(posedge clk);
		cfg_index <= REG_AUTO_REPEAT;
		cfg_data <= REG_W'(auto_rep);
		@(posedge clk);
		cfg_index <= REG_SLIDE_MODE;
		cfg_data <= REG_W'(slide);
		@(posedge clk);
		cfg_index <= REG_BUZZ_TICKS;
		cfg_data <= buzz;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	initial begin
		tick_t t;
		int    quota;
		int    n;
		int    len;
		bit    wild;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: done wins over wrong current, fault hold, not ready exits
		settings_used = 1;
		foreach (DIRECTED[i])
			pending_ticks.push_back(tick_t'({4'b0000, DIRECTED[i]}));

		for (int p = 0; p < 8; p++) begin
			wait_drained();
			case (p)
				0: program_sequencer(16'd3, 16'd2, 1'b1, 1'b1, 16'd4);
				1: program_sequencer(16'd0, 16'd0, 1'b1, 1'b1, 16'd0);
				2: program_sequencer(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
				3: program_sequencer(16'd0, 16'd1, 1'b1, 1'b1, 16'hFFFF);
				4: program_sequencer(16'd2, 16'd3, 1'b0, 1'b1, 16'd3);
				5: program_sequencer(16'd1, 16'd1, 1'b1, 1'b0, 16'd2);
				default: program_sequencer(REG_W'($urandom_range(0, 5)),
					REG_W'($urandom_range(0, 4)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), REG_W'($urandom_range(0, 6)));
			endcase
			quota = (p == 2 || p == 3) ? 30 : 65;
			n = 0;
			while (n < quota) begin
				len = $urandom_range(8, 30);
				wild = ($urandom_range(0, 99) < 15);
				for (int i = 0; i < len; i++) begin
					t = '0;
					if (wild) begin
						t[3:0] = 4'($urandom_range(0, 15));
					end else begin
						t.ready = ($urandom_range(0, 99) < 96);
						t.trig = ($urandom_range(0, 99) < 60);
						t.done = ($urandom_range(0, 99) < 30);
						t.wrong = ($urandom_range(0, 99) < 12);
					end
					pending_ticks.push_back(t);
				end
				n += len;
			end
		end

		wait_drained();
		repeat (5) @(posedge clk);
		$display("%0d ticks sent under %0d register settings, %0d results checked",
			ticks_sent, settings_used, results_checked);
		$display("phase codes reached, one bit per code: %b", phases_seen[5:0]);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("timeout: %0d results still expected", expected_status.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
